// ===== rtl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants of the postfix stack evaluator
// Stack geometry, token codes, error codes, sequencer states and the
// control word that steps the row of stack cells.
// ----------------------------------------------------------------------------
package pse_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 8;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ITER_W      = $clog2(DATA_W);

  // Token bytes
  localparam logic [7:0] TOK_ADD  = 8'h2B;
  localparam logic [7:0] TOK_SUB  = 8'h2D;
  localparam logic [7:0] TOK_MUL  = 8'h2A;
  localparam logic [7:0] TOK_DIV  = 8'h2F;
  localparam logic [8:0] TOK_ZERO = 9'h030;

  // Value returned by a pop from an empty stack
  localparam logic [DATA_W-1:0] EMPTY_VAL = '1;

  // Sticky error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNDER = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;
  localparam logic [1:0] ERR_DIVZ  = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ALU,
    S_DIV,
    S_WB,
    S_FINAL
  } state_t;

  // Per-cycle command to a stack cell
  typedef struct packed {
    logic push;  // take the value from the cell above (top cell: new data)
    logic pop;   // take the value from the cell below
  } cell_ctrl_t;

endpackage

// ===== rtl/pse_cell.sv =====
// ----------------------------------------------------------------------------
// pse_cell: one entry of the shifting stack
// Holds one value; on push it takes its upper neighbor's value, on pop
// its lower neighbor's value, otherwise it keeps its own.
// ----------------------------------------------------------------------------
module pse_cell (
  input  logic                       clk,
  input  pse_pkg::cell_ctrl_t        ctrl,
  input  logic [pse_pkg::DATA_W-1:0] up_val,
  input  logic [pse_pkg::DATA_W-1:0] down_val,
  output logic [pse_pkg::DATA_W-1:0] val
);

  // Shift up, shift down or hold
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      val <= up_val;
    end else if (ctrl.pop) begin
      val <= down_val;
    end
  end

endmodule

// ===== rtl/pse_div.sv =====
// ----------------------------------------------------------------------------
// pse_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle; the
// quotient truncates toward zero. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module pse_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pse_pkg::DATA_W-1:0] dividend,
  input  logic [pse_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [pse_pkg::DATA_W-1:0] quotient
);

  logic                        busy;
  logic [pse_pkg::ITER_W-1:0]  iter;
  logic [pse_pkg::DATA_W-1:0]  rem;
  logic [pse_pkg::DATA_W-1:0]  quo;
  logic [pse_pkg::DATA_W-1:0]  dsr;
  logic                        neg;
  logic [pse_pkg::DATA_W:0]    trial;
  logic [pse_pkg::DATA_W-1:0]  mag_a;
  logic [pse_pkg::DATA_W-1:0]  mag_b;

  // Operand magnitudes
  assign mag_a = dividend[pse_pkg::DATA_W-1] ? (~dividend + 1'b1) : dividend;
  assign mag_b = divisor[pse_pkg::DATA_W-1]  ? (~divisor + 1'b1)  : divisor;

  // Trial subtract of the shifted partial remainder
  assign trial = {rem, quo[pse_pkg::DATA_W-1]} - {1'b0, dsr};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == pse_pkg::ITER_W'(pse_pkg::DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= mag_a;
      dsr <= mag_b;
      neg <= dividend[pse_pkg::DATA_W-1] ^ divisor[pse_pkg::DATA_W-1];
    end else if (busy) begin
      if (!trial[pse_pkg::DATA_W]) begin
        rem <= trial[pse_pkg::DATA_W-1:0];
      end else begin
        rem <= {rem[pse_pkg::DATA_W-2:0], quo[pse_pkg::DATA_W-1]};
      end
      quo <= {quo[pse_pkg::DATA_W-2:0], ~trial[pse_pkg::DATA_W]};
    end
  end

  // Sign fix
  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

// ===== rtl/postfix_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: reverse Polish evaluator on a shifting stack
// Token bytes in, one 32-bit result and error code out per expression.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one token byte per beat on s_tdata, s_tlast marks the
//   last token of an expression. + - * / pop two values and push the
//   result; any other byte pushes its value minus 48.
//   Master side gives one beat per expression: m_tdata is the final popped
//   value (-1 when the stack is empty), m_tuser the first error code
//   (0 ok, 1 underflow, 2 overflow, 3 divide by zero).
//   A push is done as its token is taken; + - * and divide by zero pass the
//   ALU and write-back states; a divide also waits on the 32-step divider.
//   The last token adds a final pop, with the result beat the cycle after.
//   The stack is a row of cells at the top of which all pushes and pops
//   happen, so any depth costs the same time.
//   Reset empties the stack and clears the error code. When the receiver
//   stalls, the result waits in the output register; tokens of the next
//   expression keep being taken until its own last token needs that
//   register.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] token
  input  logic        s_tlast,   // last_token
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value
  output logic [1:0]  m_tuser    // [1:0] error
);

  localparam int D = pse_pkg::STACK_DEPTH;
  localparam int W = pse_pkg::DATA_W;

  pse_pkg::state_t         state, state_next;
  logic [pse_pkg::CNT_W-1:0] count, count_next;
  logic [1:0]              err, err_next;
  logic [7:0]              tok;
  logic                    last;
  logic [W-1:0]            opa, opb, res;
  logic [W-1:0]            res_next;
  logic                    res_load;
  logic [W-1:0]            stack_val [D];
  logic [W-1:0]            push_data;
  pse_pkg::cell_ctrl_t     ctrl_top, ctrl_rest;
  logic                    accept, is_op, out_free, out_load;
  logic [8:0]              digit;
  logic                    div_start, div_done;
  logic [W-1:0]            div_quo;
  logic [W-1:0]            final_val;
  logic [1:0]              final_err;
  logic                    has1, has2, full;

  assign s_tready = (state == pse_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign has1     = (count >= pse_pkg::CNT_W'(1));
  assign has2     = (count >= pse_pkg::CNT_W'(2));
  assign full     = (count >= pse_pkg::CNT_W'(D));
  assign is_op    = (s_tdata == pse_pkg::TOK_ADD) || (s_tdata == pse_pkg::TOK_SUB) ||
                    (s_tdata == pse_pkg::TOK_MUL) || (s_tdata == pse_pkg::TOK_DIV);
  assign digit    = {1'b0, s_tdata} - pse_pkg::TOK_ZERO;

  // Row of stack cells, top at index 0
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic [W-1:0] up_v, down_v;
    if (i == 0) begin : g_top
      assign up_v = push_data;
    end else begin : g_mid
      assign up_v = stack_val[i-1];
    end
    if (i == D - 1) begin : g_bot
      assign down_v = '0;
    end else begin : g_inner
      assign down_v = stack_val[i+1];
    end
    pse_cell u_cell (
      .clk      (clk),
      .ctrl     ((i == 0) ? ctrl_top : ctrl_rest),
      .up_val   (up_v),
      .down_val (down_v),
      .val      (stack_val[i])
    );
  end

  // Divider
  pse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (opa),
    .divisor  (opb),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Final pop
  assign final_val = has1 ? stack_val[0] : pse_pkg::EMPTY_VAL;
  assign final_err = (!has1 && err == pse_pkg::ERR_NONE) ? pse_pkg::ERR_UNDER : err;
  assign out_load  = (state == pse_pkg::S_FINAL) && out_free;

  // State register and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pse_pkg::S_IDLE;
      count <= '0;
      err   <= pse_pkg::ERR_NONE;
    end else begin
      state <= state_next;
      count <= count_next;
      err   <= err_next;
    end
  end

  // Token and operand registers
  always_ff @(posedge clk) begin
    if (accept) begin
      tok  <= s_tdata;
      last <= s_tlast;
      opb  <= has1 ? stack_val[0] : pse_pkg::EMPTY_VAL;
      opa  <= has2 ? stack_val[1] : pse_pkg::EMPTY_VAL;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= final_val;
      m_tuser <= final_err;
    end
  end

  // Next state, stack commands and arithmetic
  always_comb begin
    state_next = state;
    count_next = count;
    err_next   = err;
    ctrl_top   = '0;
    ctrl_rest  = '0;
    push_data  = res;
    res_next   = res;
    res_load   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      pse_pkg::S_IDLE: begin
        push_data = {{(W - 9){digit[8]}}, digit};
        if (accept) begin
          if (is_op) begin
            // Both pops; the left operand stays in the top cell
            if (!has2 && err == pse_pkg::ERR_NONE) begin
              err_next = pse_pkg::ERR_UNDER;
            end
            if (has2) begin
              ctrl_top.pop  = 1'b1;
              ctrl_rest.pop = 1'b1;
              count_next    = count - 1'b1;
            end else begin
              count_next = pse_pkg::CNT_W'(1);
            end
            state_next = pse_pkg::S_ALU;
          end else begin
            if (full) begin
              if (err == pse_pkg::ERR_NONE) begin
                err_next = pse_pkg::ERR_OVER;
              end
            end else begin
              ctrl_top.push  = 1'b1;
              ctrl_rest.push = 1'b1;
              count_next     = count + 1'b1;
            end
            state_next = s_tlast ? pse_pkg::S_FINAL : pse_pkg::S_IDLE;
          end
        end
      end
      pse_pkg::S_ALU: begin
        res_load   = 1'b1;
        state_next = pse_pkg::S_WB;
        case (tok)
          pse_pkg::TOK_ADD: res_next = opa + opb;
          pse_pkg::TOK_SUB: res_next = opa - opb;
          pse_pkg::TOK_MUL: res_next = opa * opb;
          default: begin
            if (opb == '0) begin
              res_next = '0;
              if (err == pse_pkg::ERR_NONE) begin
                err_next = pse_pkg::ERR_DIVZ;
              end
            end else begin
              res_load   = 1'b0;
              div_start  = 1'b1;
              state_next = pse_pkg::S_DIV;
            end
          end
        endcase
      end
      pse_pkg::S_DIV: begin
        if (div_done) begin
          res_next   = div_quo;
          res_load   = 1'b1;
          state_next = pse_pkg::S_WB;
        end
      end
      pse_pkg::S_WB: begin
        // Result replaces the top entry
        ctrl_top.push = 1'b1;
        state_next    = last ? pse_pkg::S_FINAL : pse_pkg::S_IDLE;
      end
      pse_pkg::S_FINAL: begin
        if (out_free) begin
          count_next = '0;
          err_next   = pse_pkg::ERR_NONE;
          state_next = pse_pkg::S_IDLE;
        end
      end
      default: state_next = pse_pkg::S_IDLE;
    endcase
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pse_pkg::CNT_W'(D))
    else $error("stack count above depth");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == pse_pkg::S_DIV)
    else $error("divider finished outside divide state");

  a_result_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == pse_pkg::S_FINAL))
    else $error("result beat without final pop");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    out_load |=> count == '0 && err == pse_pkg::ERR_NONE)
    else $error("stack or error not cleared after expression");

endmodule

// ===== bench/rpn_result_checker.sv =====
// ----------------------------------------------------------------------------
// rpn_result_checker: scoreboard for the postfix stack evaluator
// Watches both stream channels, evaluates every accepted token on its own
// bounded stack and compares each result beat, value and error code, with
// the oldest outstanding expression result.
// ----------------------------------------------------------------------------
module rpn_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] token
  input  logic        s_tlast,   // last_token
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [31:0] value
  input  logic [1:0]  m_tuser,   // [1:0] error
  output int          error_count,
  output int          pending_results,
  output int          tokens_seen,
  output int          results_seen
);

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  code;
  } expr_result_t;

  expr_result_t expected_results[$];
  expr_result_t want;

  // Evaluation state
  logic [31:0] eval_stack [pse_pkg::STACK_DEPTH];
  int          eval_depth;
  logic [1:0]  eval_err;

  initial begin
    error_count     = 0;
    pending_results = 0;
    tokens_seen     = 0;
    results_seen    = 0;
    eval_depth      = 0;
    eval_err        = pse_pkg::ERR_NONE;
  end

  // Sticky: only the first error of an expression is kept
  function void flag_error(input logic [1:0] code);
    if (eval_err == pse_pkg::ERR_NONE) eval_err = code;
  endfunction

  function void stack_push(input logic [31:0] v);
    if (eval_depth >= pse_pkg::STACK_DEPTH) begin
      flag_error(pse_pkg::ERR_OVER);
    end else begin
      eval_stack[eval_depth] = v;
      eval_depth++;
    end
  endfunction

  function logic [31:0] stack_pop();
    if (eval_depth == 0) begin
      flag_error(pse_pkg::ERR_UNDER);
      return pse_pkg::EMPTY_VAL;
    end
    eval_depth--;
    return eval_stack[eval_depth];
  endfunction

  // Signed divide on magnitudes, quotient truncated toward zero
  function logic [31:0] quotient_trunc(input logic [31:0] num, input logic [31:0] den);
    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic [31:0] q;
    num_mag = num[31] ? -num : num;
    den_mag = den[31] ? -den : den;
    q = num_mag / den_mag;
    return (num[31] ^ den[31]) ? -q : q;
  endfunction

  task eval_token(input logic [7:0] tok, input logic last);
    logic [31:0]  rhs;
    logic [31:0]  lhs;
    logic [31:0]  res;
    expr_result_t done;
    if (tok == pse_pkg::TOK_ADD || tok == pse_pkg::TOK_SUB ||
        tok == pse_pkg::TOK_MUL || tok == pse_pkg::TOK_DIV) begin
      rhs = stack_pop();
      lhs = stack_pop();
      case (tok)
        pse_pkg::TOK_ADD: res = lhs + rhs;
        pse_pkg::TOK_SUB: res = lhs - rhs;
        pse_pkg::TOK_MUL: res = lhs * rhs;
        default: begin
          if (rhs == '0) begin
            flag_error(pse_pkg::ERR_DIVZ);
            res = '0;
          end else begin
            res = quotient_trunc(lhs, rhs);
          end
        end
      endcase
      stack_push(res);
    end else begin
      // any other byte pushes its value minus the digit offset
      stack_push({24'b0, tok} - 32'(pse_pkg::TOK_ZERO));
    end
    if (last) begin
      done.value = stack_pop();
      done.code  = eval_err;
      expected_results.push_back(done);
      eval_depth = 0;
      eval_err   = pse_pkg::ERR_NONE;
    end
  endtask

  // Result side first, so a beat never matches an expression closed this edge
  always @(posedge clk) begin
    if (rst) begin
      eval_depth = 0;
      eval_err   = pse_pkg::ERR_NONE;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result beat: expected none, got value %0d error %0d",
                   $time, $signed(m_tdata), m_tuser);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== want.value) begin
            error_count++;
            $display("%0t: value mismatch: expected %0d, got %0d",
                     $time, $signed(want.value), $signed(m_tdata));
          end
          if (m_tuser !== want.code) begin
            error_count++;
            $display("%0t: error code mismatch: expected %0d, got %0d",
                     $time, want.code, m_tuser);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        tokens_seen++;
        eval_token(s_tdata, s_tlast);
      end
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== bench/postfix_stack_evaluator_tb.sv =====
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_tb: regression bench for the postfix evaluator
// Sends directed expressions covering each operator and edge rule, then
// random well-formed and malformed expressions with random gaps and
// receiver stalls; the checker module scores every result beat.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_tb;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] token
  logic        s_tlast;   // last_token
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] value
  logic [1:0]  m_tuser;   // [1:0] error

  int error_count;
  int pending_results;
  int tokens_seen;
  int results_seen;

  logic [7:0] expr_q[$];
  logic       tx_steady;
  int         held_cycles;

  postfix_stack_evaluator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  rpn_result_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .error_count     (error_count),
    .pending_results (pending_results),
    .tokens_seen     (tokens_seen),
    .results_seen    (results_seen)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] digit(input int d);
    return 8'(pse_pkg::TOK_ZERO + d);
  endfunction

  function automatic logic is_operator(input logic [7:0] tok);
    return tok == pse_pkg::TOK_ADD || tok == pse_pkg::TOK_SUB ||
           tok == pse_pkg::TOK_MUL || tok == pse_pkg::TOK_DIV;
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(3))
      0:       return pse_pkg::TOK_ADD;
      1:       return pse_pkg::TOK_SUB;
      2:       return pse_pkg::TOK_MUL;
      default: return pse_pkg::TOK_DIV;
    endcase
  endfunction

  // Mostly digits, sometimes any byte that is not an operator
  function automatic logic [7:0] pick_operand();
    logic [7:0] tok;
    if ($urandom_range(99) < 85) return digit($urandom_range(9));
    tok = 8'($urandom_range(255));
    while (is_operator(tok)) tok = 8'($urandom_range(255));
    return tok;
  endfunction

  // Sender idle: valid low for the requested gap
  task idle_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task send_token(input logic [7:0] tok, input logic last);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= tok;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic int sender_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task send_expr();
    foreach (expr_q[i]) begin
      idle_sender(sender_gap());
      send_token(expr_q[i], i == expr_q.size() - 1);
    end
  endtask

  // Valid postfix with random content; more operands than the depth may overflow
  task build_wellformed();
    int want_ops;
    int pushed;
    int depth;
    expr_q.delete();
    want_ops = ($urandom_range(99) < 70) ? $urandom_range(1, 6) : $urandom_range(7, 10);
    pushed = 0;
    depth  = 0;
    while (pushed < want_ops || depth > 1) begin
      if (pushed < want_ops && (depth < 2 || $urandom_range(1) == 0)) begin
        expr_q.push_back(pick_operand());
        pushed++;
        depth++;
      end else begin
        expr_q.push_back(pick_operator());
        depth--;
      end
    end
  endtask

  // Arbitrary bytes, heavy on operators, so stacks run dry
  task build_noise();
    int len;
    expr_q.delete();
    len = $urandom_range(1, 12);
    repeat (len) begin
      if ($urandom_range(1) == 0) expr_q.push_back(pick_operator());
      else                        expr_q.push_back(8'($urandom_range(255)));
    end
  endtask

  // Receiver: random stalls, steady stretches and one long hold-off
  initial begin
    int   stall_left;
    int   mode_left;
    logic rx_steady;
    logic hold_done;
    m_tready    = 1'b0;
    stall_left  = 0;
    mode_left   = 0;
    rx_steady   = 1'b0;
    hold_done   = 1'b0;
    held_cycles = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        rx_steady = ($urandom_range(2) == 0);
        mode_left = $urandom_range(100, 800);
      end
      mode_left--;
      if (!hold_done && results_seen >= 120) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (500) begin
          @(negedge clk);
          held_cycles++;
        end
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!rx_steady) begin
          if ($urandom_range(99) < 15)      stall_left = $urandom_range(1, 3);
          else if ($urandom_range(99) < 3)  stall_left = $urandom_range(10, 60);
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int   sent;
    logic drained;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    rst       = 1'b1;
    tx_steady = 1'b0;
    sent      = 0;
    drained   = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed: each operator, operand order, edge rules
    expr_q = '{digit(1), digit(2), pse_pkg::TOK_ADD};        send_expr();
    expr_q = '{digit(9), digit(5), pse_pkg::TOK_SUB};        send_expr();
    expr_q = '{digit(3), digit(4), pse_pkg::TOK_MUL};        send_expr();
    expr_q = '{digit(7), digit(3), pse_pkg::TOK_DIV};        send_expr();
    // negative dividend truncates toward zero
    expr_q = '{8'h00, digit(7), pse_pkg::TOK_DIV};           send_expr();
    // divide by zero, largest byte as dividend
    expr_q = '{8'hFF, digit(0), pse_pkg::TOK_DIV};           send_expr();
    // both pops underflow on a lone operator
    expr_q = '{pse_pkg::TOK_SUB};                            send_expr();
    // nine pushes: the last is dropped as overflow
    expr_q = '{digit(1), digit(2), digit(3), digit(4), digit(5),
               digit(6), digit(7), digit(8), digit(9)};      send_expr();
    sent = tokens_seen;

    // Random expressions
    while (sent < 1750) begin
      tx_steady = ($urandom_range(4) == 0);
      if ($urandom_range(99) < 80) build_wellformed();
      else                          build_noise();
      send_expr();
      sent += expr_q.size();
      if (!drained && sent >= 900) begin
        drained = 1'b1;
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_results == 0);
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending_results == 0);
    repeat (40) @(posedge clk);

    $display("Covered %0d tokens in %0d checked expressions.", tokens_seen, results_seen);
    $display("Receiver held off %0d cycles once; sender drained the block once mid-run.",
             held_cycles);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== postfix_stack_evaluator.f =====
rtl/pse_pkg.sv
rtl/pse_cell.sv
rtl/pse_div.sv
rtl/postfix_stack_evaluator.sv
bench/rpn_result_checker.sv
bench/postfix_stack_evaluator_tb.sv
